FILE: rtl/pressure_spike_filter_hysteresis_relay_macros.svh
// Assertion macros shared by the pressure relay checker.
`ifndef PRESSURE_SPIKE_FILTER_HYSTERESIS_RELAY_MACROS_SVH
`define PRESSURE_SPIKE_FILTER_HYSTERESIS_RELAY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSFHR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psfhr assertion failed");

// Next-cycle implication, disabled during reset.
`define PSFHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psfhr assertion failed");

`endif

FILE: rtl/psfhr_pkg.sv
// Shared types and constants of the pressure spike filter and relay.
package psfhr_pkg;

  localparam int RAW_W    = 24;
  localparam int FS_W     = 10;
  localparam int PRES_W   = 26;
  localparam int PROD_W   = RAW_W + FS_W;
  localparam int SCALE_SH = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam int SPIKE_DEPTH = 3;
  localparam int SPIKE_IDX_W = $clog2(SPIKE_DEPTH);
  localparam int SUM_W       = PRES_W + $clog2(SPIKE_DEPTH + 1);

  localparam logic [RAW_W-1:0]  BASE_COUNT_RST  = '0;
  localparam logic [FS_W-1:0]   FULL_SCALE_RST  = FS_W'(10);
  localparam logic [PRES_W-1:0] DEVIATION_RST   = PRES_W'(6554);
  localparam logic [PRES_W-1:0] PUB_DELTA_RST   = PRES_W'(6554);

  typedef enum logic [1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_FAIL     = 2'd1,
    MODE_RELAY    = 2'd2,
    MODE_PRESSURE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_COUNT    = 3'd0,
    CFG_FULL_SCALE    = 3'd1,
    CFG_LOW_THRESH    = 3'd2,
    CFG_HIGH_THRESH   = 3'd3,
    CFG_RELAY_ENABLE  = 3'd4,
    CFG_RELAY_PRESENT = 3'd5,
    CFG_DEVIATION     = 3'd6,
    CFG_PUB_DELTA     = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [RAW_W-1:0]  base_count;
    logic [FS_W-1:0]   full_scale;
    logic [PRES_W-1:0] low_threshold;
    logic [PRES_W-1:0] high_threshold;
    logic              relay_enable;
    logic              relay_present;
    logic [PRES_W-1:0] deviation_limit;
    logic [PRES_W-1:0] publish_delta;
  } cfg_t;

  // Kept pressure after the current request.
  typedef struct packed {
    logic [PRES_W-1:0] pressure;
    logic              known;
  } kept_t;

  typedef struct packed {
    logic relay_on;
    logic switched_on;
    logic switched_off;
    logic publish;
  } relay_res_t;

  function automatic logic [PRES_W-1:0] abs_diff(input logic [PRES_W-1:0] a,
                                                 input logic [PRES_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/psfhr_scale.sv
// Offset removal and scaling of a raw count to Q10.16 bar.
module psfhr_scale (
  input  logic [psfhr_pkg::RAW_W-1:0]  raw_pressure,
  input  logic [psfhr_pkg::RAW_W-1:0]  base_count,
  input  logic [psfhr_pkg::FS_W-1:0]   full_scale,
  output logic [psfhr_pkg::PRES_W-1:0] scaled
);

  logic [psfhr_pkg::RAW_W-1:0]  corr;
  logic [psfhr_pkg::PROD_W-1:0] prod;

  always_comb begin
    corr   = (raw_pressure > base_count) ? (raw_pressure - base_count) : '0;
    prod   = psfhr_pkg::PROD_W'(corr) * psfhr_pkg::PROD_W'(full_scale);
    scaled = prod[psfhr_pkg::SCALE_SH +: psfhr_pkg::PRES_W];
  end

endmodule

FILE: rtl/psfhr_filter.sv
// Spike filter: kept pressure and the rotating three-entry spike buffer.
module psfhr_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  psfhr_pkg::mode_t              mode,
  input  logic [psfhr_pkg::PRES_W-1:0]  scaled,
  input  logic [psfhr_pkg::PRES_W-1:0]  pressure_value,
  input  logic [psfhr_pkg::PRES_W-1:0]  deviation_limit,
  output psfhr_pkg::kept_t              kept_next
);

  localparam int                            DEPTH = psfhr_pkg::SPIKE_DEPTH;
  localparam int                            IDX_W = psfhr_pkg::SPIKE_IDX_W;
  localparam logic [IDX_W-1:0]              LAST  = IDX_W'(DEPTH - 1);

  psfhr_pkg::kept_t             kept;
  logic [psfhr_pkg::PRES_W-1:0] spike_store [DEPTH];
  logic [DEPTH-1:0]             spike_filled;
  logic [IDX_W-1:0]             spike_index;

  logic [DEPTH-1:0]             filled_next;
  logic [IDX_W-1:0]             index_next;
  logic [IDX_W-1:0]             idx;
  logic                         store_we;
  logic [psfhr_pkg::SUM_W-1:0]  sum;
  logic [psfhr_pkg::PRES_W-1:0] entry;

  always_comb begin
    kept_next   = kept;
    filled_next = spike_filled;
    index_next  = spike_index;
    store_we    = 1'b0;
    idx         = (spike_index <= LAST) ? spike_index : '0;
    sum         = psfhr_pkg::SUM_W'(kept.pressure);
    for (int i = 0; i < DEPTH; i++) begin
      entry = (IDX_W'(i) == idx) ? scaled : spike_store[i];
      sum   = sum + psfhr_pkg::SUM_W'(entry);
    end
    unique case (mode)
      psfhr_pkg::MODE_SAMPLE: begin
        if (scaled != '0) begin
          if (!kept.known ||
              psfhr_pkg::abs_diff(kept.pressure, scaled) <= deviation_limit) begin
            kept_next.pressure = scaled;
            kept_next.known    = 1'b1;
            filled_next        = '0;
          end else begin
            store_we         = 1'b1;
            filled_next[idx] = 1'b1;
            index_next       = (idx == LAST) ? '0 : idx + 1'b1;
            if (&filled_next) begin
              // Average kept value with the three buffered spikes.
              kept_next.pressure = sum[2 +: psfhr_pkg::PRES_W];
              filled_next        = '0;
            end
          end
        end
      end
      psfhr_pkg::MODE_PRESSURE: begin
        kept_next.pressure = pressure_value;
        kept_next.known    = 1'b1;
      end
      psfhr_pkg::MODE_FAIL, psfhr_pkg::MODE_RELAY: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept         <= '0;
      spike_filled <= '0;
      spike_index  <= '0;
    end else if (advance) begin
      kept         <= kept_next;
      spike_filled <= filled_next;
      spike_index  <= index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      spike_store[idx] <= scaled;
    end
  end

endmodule

FILE: rtl/psfhr_relay.sv
// Hysteresis relay and publish tracking.
module psfhr_relay (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  psfhr_pkg::mode_t     mode,
  input  logic                 run_logic,
  input  logic                 relay_value,
  input  psfhr_pkg::kept_t     kept_next,
  input  psfhr_pkg::cfg_t      cfg,
  output psfhr_pkg::relay_res_t res
);

  logic                         relay_state;
  logic [psfhr_pkg::PRES_W-1:0] published;
  logic [psfhr_pkg::PRES_W-1:0] published_next;
  logic                         relay_mid;
  logic                         may;

  always_comb begin
    res            = '0;
    published_next = published;
    may            = cfg.relay_present && cfg.relay_enable;
    relay_mid      = relay_state;
    res.relay_on   = relay_state;
    if (mode == psfhr_pkg::MODE_RELAY) begin
      res.relay_on = relay_value;
    end else if (run_logic) begin
      if (kept_next.known && may && !relay_state &&
          kept_next.pressure <= cfg.low_threshold) begin
        relay_mid       = 1'b1;
        res.switched_on = 1'b1;
      end
      // Overlapping thresholds switch on and back off in one request.
      res.relay_on = relay_mid;
      if (kept_next.known && may && relay_mid &&
          kept_next.pressure >= cfg.high_threshold) begin
        res.relay_on     = 1'b0;
        res.switched_off = 1'b1;
      end
      if (psfhr_pkg::abs_diff(kept_next.pressure, published) > cfg.publish_delta) begin
        published_next = kept_next.pressure;
        res.publish    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= 1'b0;
      published   <= '0;
    end else if (advance) begin
      relay_state <= res.relay_on;
      published   <= published_next;
    end
  end

endmodule

FILE: rtl/pressure_spike_filter_hysteresis_relay.sv
// Pressure spike filter with hysteresis relay: top level.
// One request per clock unless out_stall holds the result; each request is
// captured in the input register at acceptance and its result is loaded into
// the result register when it advances, where it is held while stalled.
// The scaling multiply, spike filter, relay compares and publish compare form
// the single combinational path between those two registers, which sets the
// clock rate. A stalled result does not block the input: one more request is
// held in the input register. Configuration writes take effect on the next clock.
module pressure_spike_filter_hysteresis_relay (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [psfhr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psfhr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [psfhr_pkg::RAW_W-1:0]       raw_pressure,
  input  logic                              relay_value,
  input  logic [psfhr_pkg::PRES_W-1:0]      pressure_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              relay_on,
  output logic                              switched_on,
  output logic                              switched_off,
  output logic                              publish,
  output logic [psfhr_pkg::PRES_W-1:0]      pressure_out,
  output logic                              pressure_known
);

  psfhr_pkg::cfg_t cfg;

  logic                         q_valid;
  psfhr_pkg::mode_t             q_mode;
  logic [psfhr_pkg::RAW_W-1:0]  q_raw;
  logic                         q_relay;
  logic [psfhr_pkg::PRES_W-1:0] q_pressure;

  logic                         out_free;
  logic                         advance;
  logic                         accept;
  logic                         run_logic;
  logic [psfhr_pkg::PRES_W-1:0] scaled;
  psfhr_pkg::kept_t             kept_next;
  psfhr_pkg::relay_res_t        res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = q_valid && out_free;
  assign in_stall = q_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_count      <= psfhr_pkg::BASE_COUNT_RST;
      cfg.full_scale      <= psfhr_pkg::FULL_SCALE_RST;
      cfg.low_threshold   <= '0;
      cfg.high_threshold  <= '0;
      cfg.relay_enable    <= 1'b1;
      cfg.relay_present   <= 1'b0;
      cfg.deviation_limit <= psfhr_pkg::DEVIATION_RST;
      cfg.publish_delta   <= psfhr_pkg::PUB_DELTA_RST;
    end else if (cfg_we) begin
      unique case (psfhr_pkg::cfg_index_t'(cfg_index))
        psfhr_pkg::CFG_BASE_COUNT:    cfg.base_count      <= cfg_data[psfhr_pkg::RAW_W-1:0];
        psfhr_pkg::CFG_FULL_SCALE:    cfg.full_scale      <= cfg_data[psfhr_pkg::FS_W-1:0];
        psfhr_pkg::CFG_LOW_THRESH:    cfg.low_threshold   <= cfg_data;
        psfhr_pkg::CFG_HIGH_THRESH:   cfg.high_threshold  <= cfg_data;
        psfhr_pkg::CFG_RELAY_ENABLE:  cfg.relay_enable    <= cfg_data[0];
        psfhr_pkg::CFG_RELAY_PRESENT: cfg.relay_present   <= cfg_data[0];
        psfhr_pkg::CFG_DEVIATION:     cfg.deviation_limit <= cfg_data;
        psfhr_pkg::CFG_PUB_DELTA:     cfg.publish_delta   <= cfg_data;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode     <= psfhr_pkg::mode_t'(mode);
      q_raw      <= raw_pressure;
      q_relay    <= relay_value;
      q_pressure <= pressure_value;
    end
  end

  psfhr_scale u_scale (
    .raw_pressure (q_raw),
    .base_count   (cfg.base_count),
    .full_scale   (cfg.full_scale),
    .scaled       (scaled)
  );

  psfhr_filter u_filter (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .mode            (q_mode),
    .scaled          (scaled),
    .pressure_value  (q_pressure),
    .deviation_limit (cfg.deviation_limit),
    .kept_next       (kept_next)
  );

  // Zero sample ends the request with no relay or publish work.
  assign run_logic = (q_mode == psfhr_pkg::MODE_FAIL) ||
                     (q_mode == psfhr_pkg::MODE_SAMPLE && scaled != '0);

  psfhr_relay u_relay (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .mode        (q_mode),
    .run_logic   (run_logic),
    .relay_value (q_relay),
    .kept_next   (kept_next),
    .cfg         (cfg),
    .res         (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_on       <= res.relay_on;
      switched_on    <= res.switched_on;
      switched_off   <= res.switched_off;
      publish        <= res.publish;
      pressure_out   <= kept_next.pressure;
      pressure_known <= kept_next.known;
    end
  end

endmodule

FILE: rtl/psfhr_checker.sv
// Port-level checker for the pressure relay, bound to the top level.
`include "pressure_spike_filter_hysteresis_relay_macros.svh"

module psfhr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         relay_on,
  input logic                         switched_on,
  input logic                         switched_off,
  input logic                         publish,
  input logic [psfhr_pkg::PRES_W-1:0] pressure_out,
  input logic                         pressure_known
);

  `PSFHR_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pressure_out))
  `PSFHR_ASSERT_NOW(a_off_wins, clk, rst, out_valid && switched_off, !relay_on)
  `PSFHR_ASSERT_NOW(a_on_sticks, clk, rst, out_valid && switched_on && !switched_off, relay_on)
  `PSFHR_ASSERT_NOW(a_pub_known, clk, rst, out_valid && publish, pressure_known)
  `PSFHR_ASSERT_NOW(a_unknown_zero, clk, rst, out_valid && !pressure_known, pressure_out == '0)

endmodule

bind pressure_spike_filter_hysteresis_relay psfhr_checker u_psfhr_checker (.*);
